/* sv/ran2_shuffled_combined_lcg_core_macros.svh */
// Assertion shorthands shared by the checkers of the generator core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RAN2_SHUFFLED_COMBINED_LCG_CORE_MACROS_SVH
`define RAN2_SHUFFLED_COMBINED_LCG_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAN2_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ran2 core check failed");

// The consequent must hold in the cycle after the antecedent.
`define RAN2_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ran2 core check failed");

`endif

/* sv/ran2_pkg.sv */
`default_nettype none

package ran2_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int VAL_W      = 31;
    localparam int MUL_W      = 16;
    localparam int FOLD_W     = 8;
    localparam int PROD_W     = VAL_W + MUL_W;

    localparam logic [VAL_W-1:0] MOD_A = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD_B = 31'd2147483399;
    localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
    localparam logic [MUL_W-1:0] MUL_B = 16'd40692;

    // 2^31 is congruent to these small values under each modulus.
    localparam longint TWO_POW_31 = 64'd2147483648;
    localparam logic [FOLD_W-1:0] FOLD_A = FOLD_W'(TWO_POW_31 - longint'(MOD_A));
    localparam logic [FOLD_W-1:0] FOLD_B = FOLD_W'(TWO_POW_31 - longint'(MOD_B));

    localparam logic [VAL_W-1:0] SPAN_A = MOD_A - 31'd1;

    // Slot selection: divide the last output by SLOT_DIV through a reciprocal.
    localparam longint SLOT_DIV = 64'd1 + longint'(SPAN_A) / TABLE_SIZE;
    localparam int     RECIP_SH = 37;
    localparam longint RECIP    = (64'd1 << RECIP_SH) / SLOT_DIV;
    localparam int     Q_W      = SLOT_W + 1;
    localparam int     QP_W     = RECIP_SH + Q_W;

    localparam int WARM_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WARM   = 5'b00010,
        ST_SLOT   = 5'b00100,
        ST_READ   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
        logic sel_b;
    } lcg_ctl_t;

endpackage

`default_nettype wire

/* sv/ran2_ram.sv */
`default_nettype none

module ran2_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ran2_lcg.sv */
`default_nettype none

// Three-stage multiply and reduce: x * mul mod m, with m = 2^31 - c.
// The high part of the product is folded back twice, then one subtract.
module ran2_lcg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ran2_pkg::lcg_ctl_t           ctl,
    input  wire logic [ran2_pkg::VAL_W-1:0]   x,
    output logic      [ran2_pkg::VAL_W-1:0]   result,
    output logic                              done
);

    localparam int VW = ran2_pkg::VAL_W;
    localparam int PW = ran2_pkg::PROD_W;

    logic                 v1_reg, v2_reg, done_reg;
    logic                 sel1_reg, sel2_reg;
    logic [PW-1:0]        prod_reg;
    logic [VW:0]          fold_reg;
    logic [VW-1:0]        result_reg;

    logic [ran2_pkg::MUL_W-1:0]  mul;
    logic [PW-1:0]               prod_next;
    logic [ran2_pkg::FOLD_W-1:0] fold_c1, fold_c2;
    logic [VW:0]                 fold_next;
    logic [VW:0]                 f2;
    logic [VW:0]                 mod_ext;
    logic [VW:0]                 res_next;

    always_comb
    begin
        mul       = ctl.sel_b ? ran2_pkg::MUL_B : ran2_pkg::MUL_A;
        prod_next = {{ran2_pkg::MUL_W{1'b0}}, x} * {{VW{1'b0}}, mul};

        fold_c1   = sel1_reg ? ran2_pkg::FOLD_B : ran2_pkg::FOLD_A;
        fold_next = (VW+1)'(prod_reg[PW-1:VW]) * (VW+1)'(fold_c1)
                  + (VW+1)'(prod_reg[VW-1:0]);

        fold_c2   = sel2_reg ? ran2_pkg::FOLD_B : ran2_pkg::FOLD_A;
        mod_ext   = {1'b0, (sel2_reg ? ran2_pkg::MOD_B : ran2_pkg::MOD_A)};
        f2        = (VW+1)'(fold_reg[VW] ? fold_c2 : {ran2_pkg::FOLD_W{1'b0}})
                  + {1'b0, fold_reg[VW-1:0]};
        res_next  = (f2 >= mod_ext) ? (f2 - mod_ext) : f2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctl.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            prod_reg <= prod_next;
            sel1_reg <= ctl.sel_b;
        end
        if (v1_reg)
        begin
            fold_reg <= fold_next;
            sel2_reg <= sel1_reg;
        end
        // The result holds until the next step, so a stalled consumer keeps it.
        if (v2_reg)
        begin
            result_reg <= res_next[VW-1:0];
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

/* sv/ran2_shuffled_combined_lcg_core.sv */
// Combined two-generator random number source with a 32-entry shuffle table.
// Input channel (in_valid/in_ready): command and seed. A seed command loads
// both generators and runs 40 warm-up steps that fill the table; it gives
// no result and keeps in_ready low until its last warm-up step is done.
// A draw command gives one value on the output channel (out_valid/out_ready).
// A draw passes through the slot, read and finish states; its result is
// registered as it leaves the finish state, and no new item is taken before
// then. Its pace is set by the three-stage multiply-and-reduce units and
// the table read, which overlap with the slot division.
// Warm-up steps run one after another through the first generator's
// unit, as every step depends on the one before it.
// The output register parts the two channels: a new item is taken while a
// result waits. A draw that finishes while the previous result is still not
// taken waits in its last stage until the receiver frees the register.
// After reset both generators hold 1 and the last output is 0; the table
// holds nothing meaningful until the first seed, so a draw must not come
// first.
`default_nettype none

module ran2_shuffled_combined_lcg_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        command,
    input  wire logic signed [31:0]          seed,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [ran2_pkg::VAL_W-1:0]  value
);

    localparam int VW = ran2_pkg::VAL_W;
    localparam int SW = ran2_pkg::SLOT_W;
    localparam int QW = ran2_pkg::Q_W;
    localparam int CW = ran2_pkg::CNT_W;

    ran2_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [VW-1:0]    first_gen_reg, first_gen_next;
    logic [VW-1:0]    second_gen_reg, second_gen_next;
    logic [VW-1:0]    last_reg, last_next;
    logic [QW-1:0]    q0_reg, q0_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             out_valid_reg, out_valid_next;
    logic [VW-1:0]    value_reg, value_next;

    logic             in_fire;
    logic             finish_fire;
    logic             warm_last;
    logic             warm_wr;
    logic [VW-1:0]    seed_start;
    logic [ran2_pkg::QP_W-1:0] q_prod;
    logic [31:0]      rem;
    logic [QW-1:0]    q_fix;
    logic [CW-1:0]    warm_addr;
    logic [31:0]      diff;
    logic [31:0]      wrapped;
    logic [VW-1:0]    y;

    ran2_pkg::lcg_ctl_t ctl_a, ctl_b;
    logic [VW-1:0]      x_a;
    logic [VW-1:0]      res_a, res_b;
    logic               done_a, done_b;

    logic               ram_wr_en;
    logic [SW-1:0]      ram_wr_addr;
    logic [VW-1:0]      ram_wr_data;
    logic               ram_rd_en;
    logic [VW-1:0]      ram_rd_data;

    assign in_ready  = (state_reg == ran2_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // max(seed + 1, 1), saturated to 31 bits at the top of the range.
    always_comb
    begin
        if (seed[31] || (seed == 32'sd0))
        begin
            seed_start = VW'(1);
        end
        else if (seed == 32'sh7FFFFFFF)
        begin
            seed_start = {VW{1'b1}};
        end
        else
        begin
            seed_start = seed[VW-1:0] + VW'(1);
        end
    end

    // Slot estimate from the reciprocal; it is exact or one too small.
    assign q_prod = ran2_pkg::QP_W'(last_reg) * ran2_pkg::QP_W'(ran2_pkg::RECIP);
    assign q0_next = q_prod[ran2_pkg::RECIP_SH +: QW];

    always_comb
    begin
        rem = 32'(last_reg) - 32'(q0_reg) * 32'(ran2_pkg::SLOT_DIV);
        q_fix = q0_reg + ((rem >= 32'(ran2_pkg::SLOT_DIV)) ? QW'(1) : QW'(0));
        if (q_fix >= QW'(ran2_pkg::TABLE_SIZE))
        begin
            slot_next = SW'(ran2_pkg::TABLE_SIZE - 1);
        end
        else
        begin
            slot_next = q_fix[SW-1:0];
        end
    end

    assign warm_last = (count_reg == CW'(ran2_pkg::WARM_STEPS - 1));
    assign warm_addr = CW'(ran2_pkg::WARM_STEPS - 1) - count_reg;
    assign warm_wr   = (state_reg == ran2_pkg::ST_WARM) && done_a
                    && (count_reg >= CW'(ran2_pkg::WARM_STEPS - ran2_pkg::TABLE_SIZE));

    assign finish_fire = (state_reg == ran2_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // New output: table entry minus the second generator, wrapped into range.
    always_comb
    begin
        diff    = {1'b0, ram_rd_data} - {1'b0, res_b};
        wrapped = {1'b0, ram_rd_data} + {1'b0, ran2_pkg::SPAN_A} - {1'b0, res_b};
        y       = diff[31] ? wrapped[VW-1:0] : diff[VW-1:0];
    end

    // Generator units: the first one also runs the warm-up, fed from its own result.
    always_comb
    begin
        ctl_a.sel_b = 1'b0;
        ctl_a.start = in_fire
                   || ((state_reg == ran2_pkg::ST_WARM) && done_a && !warm_last);
        ctl_b.sel_b = 1'b1;
        ctl_b.start = in_fire && (command == ran2_pkg::CMD_DRAW);
        if (state_reg == ran2_pkg::ST_IDLE)
        begin
            x_a = (command == ran2_pkg::CMD_SEED) ? seed_start : first_gen_reg;
        end
        else
        begin
            x_a = res_a;
        end
    end

    ran2_lcg u_lcg_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_a),
        .x      (x_a),
        .result (res_a),
        .done   (done_a)
    );

    ran2_lcg u_lcg_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_b),
        .x      (second_gen_reg),
        .result (res_b),
        .done   (done_b)
    );

    always_comb
    begin
        ram_wr_en   = warm_wr || finish_fire;
        ram_wr_addr = finish_fire ? slot_reg : warm_addr[SW-1:0];
        ram_wr_data = res_a;
        ram_rd_en   = (state_reg == ran2_pkg::ST_READ);
    end

    ran2_ram #(
        .WIDTH (VW),
        .DEPTH (ran2_pkg::TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        first_gen_next  = first_gen_reg;
        second_gen_next = second_gen_reg;
        last_next       = last_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            ran2_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == ran2_pkg::CMD_SEED)
                    begin
                        first_gen_next  = seed_start;
                        second_gen_next = seed_start;
                        count_next      = '0;
                        state_next      = ran2_pkg::ST_WARM;
                    end
                    else
                    begin
                        state_next = ran2_pkg::ST_SLOT;
                    end
                end
            end
            ran2_pkg::ST_WARM:
            begin
                if (done_a)
                begin
                    first_gen_next = res_a;
                    if (warm_last)
                    begin
                        last_next  = res_a;
                        state_next = ran2_pkg::ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ran2_pkg::ST_SLOT:
            begin
                state_next = ran2_pkg::ST_READ;
            end
            ran2_pkg::ST_READ:
            begin
                state_next = ran2_pkg::ST_FINISH;
            end
            ran2_pkg::ST_FINISH:
            begin
                // Both generator results are ready here; done_b only marks the
                // cycle they arrived, so the stored results are used instead.
                if (finish_fire)
                begin
                    first_gen_next  = res_a;
                    second_gen_next = res_b;
                    last_next       = y;
                    value_next      = y;
                    out_valid_next  = 1'b1;
                    state_next      = ran2_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ran2_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ran2_pkg::ST_IDLE;
            count_reg      <= '0;
            first_gen_reg  <= VW'(1);
            second_gen_reg <= VW'(1);
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            first_gen_reg  <= first_gen_next;
            second_gen_reg <= second_gen_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (in_fire)
        begin
            q0_reg <= q0_next;
        end
        if ((state_reg == ran2_pkg::ST_SLOT) && !done_b)
        begin
            slot_reg <= slot_next;
        end
        else if (state_reg == ran2_pkg::ST_SLOT)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ran2_chk.sv */
`default_nettype none
`include "ran2_shuffled_combined_lcg_core_macros.svh"

module ran2_chk (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       command,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [ran2_pkg::VAL_W-1:0] value
);

    // A result that is not taken stays on the port unchanged.
    `RAN2_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value))

    // Outputs never leave the range of the combined generator.
    `RAN2_CHECK_NOW(a_value_range, out_valid, value <= ran2_pkg::SPAN_A)

    // One item at a time: a transfer makes the block busy in the next cycle.
    `RAN2_CHECK_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

    // Seeding never produces a result of its own.
    `RAN2_CHECK_NEXT(a_seed_silent,
        in_valid && in_ready && (command == ran2_pkg::CMD_SEED) && !out_valid, !out_valid)

endmodule

bind ran2_shuffled_combined_lcg_core ran2_chk u_ran2_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
);

`default_nettype wire
